FILE: hw/rtl/floppy_track_bit_stream_unit_defines.svh
// Assertion macros for the floppy track bit stream unit
`ifndef FLOPPY_TRACK_BIT_STREAM_UNIT_DEFINES_SVH
`define FLOPPY_TRACK_BIT_STREAM_UNIT_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle
`define FTB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle
`define FTB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/ftbs_pkg.sv
// ---------------------------------------------------------------------------
// ftbs_pkg
// Types and constants shared by the floppy track bit stream unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package ftbs_pkg;
  localparam int unsigned NumQtracks = 160;
  localparam int unsigned TrackBytes = 8192;
  localparam int unsigned QtW = 8;
  localparam int unsigned BpW = $clog2(TrackBytes);
  localparam int unsigned StoreAw = QtW + BpW;

  localparam logic [2:0] ReqRotate = 3'd0;
  localparam logic [2:0] ReqRead   = 3'd1;
  localparam logic [2:0] ReqWrite  = 3'd2;
  localparam logic [2:0] ReqSetLen = 3'd3;
  localparam logic [2:0] ReqLoad   = 3'd4;

  localparam logic CfgDiskLoaded   = 1'b0;
  localparam logic CfgWriteEnabled = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  quarter_track;
    logic        write_value;
    logic [15:0] track_length;
    logic [12:0] byte_index;
    logic [7:0]  byte_value;
  } req_t;

  typedef struct packed {
    logic        read_bit;
    logic        track_present;
    logic [15:0] bit_position;
    logic        was_modified;
    logic        status;
  } res_t;

  typedef enum logic [3:0] {
    StIdle, StLenRd, StLenWait, StOldRd, StOldWait, StDivRun, StDivDone,
    StStRd, StStWait, StStWr, StNbNext, StFinish
  } state_e;

  // Divider request/response between the controller and the divide unit
  typedef struct packed {
    logic        start;
    logic [33:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [33:0] quotient;
  } div_rsp_t;
endpackage

FILE: hw/rtl/ftbs_divider.sv
// ---------------------------------------------------------------------------
// ftbs_divider
// Radix-2 restoring divider, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ftbs_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftbs_pkg::div_req_t  req_i,
  output ftbs_pkg::div_rsp_t  rsp_o
);
  logic [33:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [16:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [17:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[33]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 6'd34;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 17'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[32:0], 1'b1};
      end else begin
        rem_d = trial[16:0];
        quo_d = {quo_q[32:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

FILE: hw/rtl/floppy_track_bit_stream_unit.sv
// ---------------------------------------------------------------------------
// floppy_track_bit_stream_unit
// Spinning floppy disk as a bit stream over a track memory and length table.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_i with start high while busy is low; the
//   item is taken at that edge. One result beat follows on res_o, marked by
//   done_o for a single cycle; the receiver cannot stall it.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i/cfg_data_i;
//   index 0 disk_loaded, 1 write_enabled. Ready only while idle.
// Sequencing:
//   Set length, load byte and ignored requests read the length table and
//   finish; read and rotate without rescale add a store or table read;
//   rotate with rescale waits on the serial divider (34 quotient bits);
//   write does one store read-modify-write per quarter track through the
//   single store port, skipping neighbours off the disk. done_o is high in
//   the first idle cycle; the next item can be taken at the edge ending it.
//   Items are handled one at a time.
// Reset:
//   Length table clears at once through valid bits; head position, dirty
//   and disk_loaded clear, write_enabled sets; the track store is undefined until loaded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "floppy_track_bit_stream_unit_defines.svh"
module floppy_track_bit_stream_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ftbs_pkg::req_t    req_i,
  output logic              done_o,
  output ftbs_pkg::res_t    res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [0:0]        cfg_data_i
);
  localparam int unsigned BpW = ftbs_pkg::BpW;

  ftbs_pkg::state_e st_q, st_d;
  ftbs_pkg::req_t   req_q;
  ftbs_pkg::res_t   res_q, res_d;
  logic done_q, done_d;

  logic loaded_q, wen_q;
  logic [BpW-1:0] bpos_q, bpos_d;
  logic [2:0] bidx_q, bidx_d;
  logic [7:0] prev_q, prev_d;
  logic dirty_q, dirty_d;
  logic [15:0] len_q, len_d;
  logic [15:0] old_q, old_d;
  logic rbit_q, rbit_d;
  logic status_q, status_d;
  logic [1:0] nb_q, nb_d;

  // Length table: 160 words, valid bits stand for the reset value
  logic [15:0] ltab [ftbs_pkg::NumQtracks];
  logic [ftbs_pkg::NumQtracks-1:0] lval_q;
  logic [15:0] lrd_q;
  logic lrd_v_q;
  logic ltab_we, ltab_re;
  logic [7:0] ltab_ra;

  // Track store, one port
  logic [7:0] tstore [2**ftbs_pkg::StoreAw];
  logic [7:0] trd_q;
  logic st_we, st_re;
  logic [ftbs_pkg::StoreAw-1:0] st_a;
  logic [7:0] st_wd;

  ftbs_pkg::div_req_t dreq, dreq_g;
  ftbs_pkg::div_rsp_t drsp;
  logic div_sent_q;

  ftbs_divider u_div (.clk_i, .rst_ni, .req_i(dreq_g), .rsp_o(drsp));

  logic legal, accept;
  logic [7:0] qt, nb_qt;
  logic [15:0] pos_cur, diff;
  logic [29:0] diff_x;
  logic [15:0] rq;
  logic [7:0] mask;
  logic nb_ok;

  assign qt      = req_q.quarter_track;
  assign legal   = loaded_q && (qt < 8'(ftbs_pkg::NumQtracks));
  assign accept  = start && !busy;
  assign busy    = st_q != ftbs_pkg::StIdle;
  assign cfg_ready_o = !busy;
  assign pos_cur = {bpos_q, bidx_q};
  assign diff    = (old_d > len_q) ? old_d - len_q : len_q - old_d;
  assign diff_x  = 30'(diff) * 30'd10000;
  assign mask    = 8'h80 >> bidx_q;

  // Neighbour sequence: 0 self, 1 lower, 2 upper
  always_comb begin
    case (nb_q)
      2'd0:    begin nb_qt = qt;        nb_ok = 1'b1; end
      2'd1:    begin nb_qt = qt - 8'd1; nb_ok = qt != 8'd0; end
      2'd2:    begin
        nb_qt = qt + 8'd1;
        nb_ok = (9'(qt) + 9'd1) < 9'(ftbs_pkg::NumQtracks);
      end
      default: begin nb_qt = qt;        nb_ok = 1'b0; end
    endcase
  end

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ftbs_pkg::StIdle:    if (accept) st_d = ftbs_pkg::StLenRd;
      ftbs_pkg::StLenRd:   st_d = ftbs_pkg::StLenWait;
      ftbs_pkg::StLenWait: begin
        if (!legal) st_d = ftbs_pkg::StFinish;
        else begin
          case (req_q.req_type)
            ftbs_pkg::ReqRotate: st_d = ftbs_pkg::StOldRd;
            ftbs_pkg::ReqRead:   st_d = ftbs_pkg::StStRd;
            ftbs_pkg::ReqWrite:  st_d = wen_q ? ftbs_pkg::StStRd : ftbs_pkg::StFinish;
            default:             st_d = ftbs_pkg::StFinish;
          endcase
        end
      end
      ftbs_pkg::StOldRd:   st_d = ftbs_pkg::StOldWait;
      ftbs_pkg::StOldWait: begin
        if (len_q != 16'd0 && qt != prev_q && old_d != 16'd0 &&
            diff_x >= 30'(old_d)) st_d = ftbs_pkg::StDivRun;
        else st_d = ftbs_pkg::StFinish;
      end
      ftbs_pkg::StDivRun:  if (drsp.done) st_d = ftbs_pkg::StDivDone;
      ftbs_pkg::StDivDone: st_d = ftbs_pkg::StFinish;
      ftbs_pkg::StStRd:    st_d = ftbs_pkg::StStWait;
      ftbs_pkg::StStWait:  st_d = (req_q.req_type == ftbs_pkg::ReqRead) ?
                                  ftbs_pkg::StFinish : ftbs_pkg::StStWr;
      ftbs_pkg::StStWr:    st_d = ftbs_pkg::StNbNext;
      ftbs_pkg::StNbNext:  st_d = (nb_q == 2'd3) ? ftbs_pkg::StFinish :
                                  (nb_ok ? ftbs_pkg::StStRd : ftbs_pkg::StNbNext);
      ftbs_pkg::StFinish:  st_d = ftbs_pkg::StIdle;
      default:             st_d = ftbs_pkg::StIdle;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    bpos_d = bpos_q; bidx_d = bidx_q; prev_d = prev_q; dirty_d = dirty_q;
    len_d = len_q; old_d = old_q; rbit_d = rbit_q; status_d = status_q;
    nb_d = nb_q; res_d = res_q; done_d = 1'b0;
    ltab_we = 1'b0; ltab_re = 1'b0; ltab_ra = qt;
    st_we = 1'b0; st_re = 1'b0; st_wd = trd_q;
    st_a = {nb_qt, bpos_q};
    dreq.start = 1'b0;
    dreq.dividend = 34'({pos_cur, 1'b0}) * 34'(len_q) + 34'(old_q);
    dreq.divisor = {old_q, 1'b0};
    rq = (drsp.quotient > 34'h0FFFF) ? 16'hFFFF : drsp.quotient[15:0];
    case (st_q)
      ftbs_pkg::StIdle: begin
        rbit_d = 1'b0; status_d = 1'b1; nb_d = 2'd0;
      end
      ftbs_pkg::StLenRd: ltab_re = 1'b1;
      ftbs_pkg::StLenWait: begin
        len_d = lrd_v_q ? lrd_q : 16'd0;
        if (legal) begin
          case (req_q.req_type)
            ftbs_pkg::ReqRotate: begin
              status_d = 1'b0;
              bidx_d = bidx_q + 3'd1;
              if (bidx_q == 3'd7) bpos_d = bpos_q + 1'b1;
            end
            ftbs_pkg::ReqRead: status_d = 1'b0;
            ftbs_pkg::ReqWrite: if (wen_q) begin
              status_d = 1'b0; dirty_d = 1'b1;
            end
            ftbs_pkg::ReqSetLen: begin
              status_d = 1'b0; ltab_we = 1'b1;
              len_d = req_q.track_length;
            end
            ftbs_pkg::ReqLoad: if (32'(req_q.byte_index) < ftbs_pkg::TrackBytes) begin
              status_d = 1'b0; st_we = 1'b1; st_wd = req_q.byte_value;
              st_a = {qt, req_q.byte_index[BpW-1:0]};
            end
            default: ;
          endcase
        end
      end
      ftbs_pkg::StOldRd: begin ltab_re = 1'b1; ltab_ra = prev_q; end
      ftbs_pkg::StOldWait: begin
        old_d = lrd_v_q ? lrd_q : 16'd0;
        if (len_q != 16'd0 && qt != prev_q) prev_d = qt;
      end
      ftbs_pkg::StDivDone: begin
        bpos_d = rq[15:3]; bidx_d = rq[2:0];
      end
      ftbs_pkg::StStRd: st_re = 1'b1;
      ftbs_pkg::StStWait: if (req_q.req_type == ftbs_pkg::ReqRead) rbit_d = |(trd_q & mask);
      ftbs_pkg::StStWr: begin
        st_we = 1'b1;
        st_wd = req_q.write_value ? (trd_q | mask) : (trd_q & ~mask);
        nb_d = nb_q + 2'd1;
      end
      // Skip a neighbour that lies outside the disk
      ftbs_pkg::StNbNext: if (!nb_ok) nb_d = nb_q + 2'd1;
      ftbs_pkg::StFinish: begin
        if (legal && req_q.req_type == ftbs_pkg::ReqRotate && len_q != 16'd0 &&
            len_q <= pos_cur) begin
          bpos_d = '0; bidx_d = '0;
        end
        done_d = 1'b1;
        res_d.read_bit = rbit_q;
        res_d.track_present = legal && len_q != 16'd0;
        res_d.bit_position = (len_q != 16'd0 && legal &&
            req_q.req_type == ftbs_pkg::ReqRotate && len_q <= pos_cur) ? 16'd0 : pos_cur;
        res_d.was_modified = dirty_q;
        res_d.status = status_q;
      end
      default: ;
    endcase
  end

  // Divider launch guard: one start per run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_sent_q <= 1'b0;
    else if (st_q != ftbs_pkg::StDivRun) div_sent_q <= 1'b0;
    else div_sent_q <= 1'b1;
  end
  always_comb begin
    dreq_g = dreq;
    dreq_g.start = (st_q == ftbs_pkg::StDivRun) && !div_sent_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ftbs_pkg::StIdle; done_q <= 1'b0;
      loaded_q <= 1'b0; wen_q <= 1'b1;
      bpos_q <= '0; bidx_q <= '0; prev_q <= '0; dirty_q <= 1'b0;
      lval_q <= '0; nb_q <= '0; lrd_v_q <= 1'b0;
    end else begin
      st_q <= st_d; done_q <= done_d;
      bpos_q <= bpos_d; bidx_q <= bidx_d; prev_q <= prev_d; dirty_q <= dirty_d;
      nb_q <= nb_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == ftbs_pkg::CfgDiskLoaded) loaded_q <= cfg_data_i[0];
        else wen_q <= cfg_data_i[0];
      end
      if (ltab_we) lval_q[qt] <= 1'b1;
      if (ltab_re) lrd_v_q <= lval_q[ltab_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    res_q <= res_d; len_q <= len_d; old_q <= old_d;
    rbit_q <= rbit_d; status_q <= status_d;
    if (ltab_we) ltab[qt] <= req_q.track_length;
    if (ltab_re) lrd_q <= ltab[ltab_ra];
    if (st_we) tstore[st_a] <= st_wd;
    if (st_re) trd_q <= tstore[st_a];
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `FTB_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `FTB_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy)
  `FTB_ASSERT_IMP(a_done_one, clk_i, rst_ni, done_o, !$past(done_o))
endmodule

FILE: sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the floppy track bit stream unit: directed checks
// of each request and corner, then constrained random traffic over a small
// working set of quarter tracks, all results compared against a predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  localparam logic [2:0] ReqRsvdA = 3'd5;
  localparam logic [2:0] ReqRsvdB = 3'd6;
  localparam logic [2:0] ReqRsvdC = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  ftbs_pkg::req_t req_i = '0;
  logic done_o;
  ftbs_pkg::res_t res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [0:0] cfg_data_i = 1'b0;

  floppy_track_bit_stream_unit u_dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted disk state
  logic [15:0] len_tbl [ftbs_pkg::NumQtracks];
  logic [7:0]  disk_bytes [int unsigned];
  logic [12:0] head_byte;
  logic [2:0]  head_bit;
  logic [7:0]  last_qt;
  logic        dirty;
  logic        loaded;
  logic        wr_en;

  ftbs_pkg::res_t result_q [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int rescales = 0;
  int idle_pct = 35;

  function automatic int unsigned byte_key(int unsigned qt);
    return qt * ftbs_pkg::TrackBytes + head_byte;
  endfunction

  function automatic void set_bit(int unsigned qt, logic v);
    int unsigned k;
    k = byte_key(qt);
    disk_bytes[k][7 - head_bit] = v;
  endfunction

  function automatic void spin_head(int unsigned qt);
    longint unsigned len, old, diff, p, r, pos;
    head_bit = head_bit + 3'd1;
    if (head_bit == 3'd0) head_byte = head_byte + 13'd1;
    len = len_tbl[qt];
    if (len == 0) return;
    if (qt != last_qt) begin
      old = len_tbl[last_qt];
      diff = (old > len) ? old - len : len - old;
      if (old != 0 && diff * 10000 >= old) begin
        p = {head_byte, head_bit};
        r = (2 * p * len + old) / (2 * old);
        if (r > 64'hFFFF) r = 64'hFFFF;
        {head_byte, head_bit} = r[15:0];
        rescales++;
      end
      last_qt = qt[7:0];
    end
    pos = {head_byte, head_bit};
    if (len <= pos) begin
      head_byte = '0;
      head_bit = '0;
    end
  endfunction

  function automatic ftbs_pkg::res_t predict_result(ftbs_pkg::req_t r);
    ftbs_pkg::res_t o;
    logic legal;
    int unsigned qt;
    qt = r.quarter_track;
    legal = loaded && qt < ftbs_pkg::NumQtracks;
    o = '0;
    o.status = 1'b1;
    if (legal) begin
      case (r.req_type)
        ftbs_pkg::ReqRotate: begin
          spin_head(qt);
          o.status = 1'b0;
        end
        ftbs_pkg::ReqRead: begin
          o.read_bit = disk_bytes[byte_key(qt)][7 - head_bit];
          o.status = 1'b0;
        end
        ftbs_pkg::ReqWrite: begin
          if (wr_en) begin
            set_bit(qt, r.write_value);
            if (qt > 0) set_bit(qt - 1, r.write_value);
            if (qt + 1 < ftbs_pkg::NumQtracks) set_bit(qt + 1, r.write_value);
            dirty = 1'b1;
            o.status = 1'b0;
          end
        end
        ftbs_pkg::ReqSetLen: begin
          len_tbl[qt] = r.track_length;
          o.status = 1'b0;
        end
        ftbs_pkg::ReqLoad: begin
          disk_bytes[qt * ftbs_pkg::TrackBytes + r.byte_index] = r.byte_value;
          o.status = 1'b0;
        end
        default: ;
      endcase
    end
    o.track_present = legal && len_tbl[qt] != 0;
    o.bit_position = {head_byte, head_bit};
    o.was_modified = dirty;
    return o;
  endfunction

  // Drive one command beat; take it on the edge where busy is low
  task automatic send_beat(ftbs_pkg::req_t r);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    result_q.push_back(predict_result(r));
    items_sent++;
  endtask

  // Load any byte the coming read or write will touch that was never set
  task automatic issue(ftbs_pkg::req_t r);
    ftbs_pkg::req_t ld;
    int unsigned qt, lo, hi;
    qt = r.quarter_track;
    if (loaded && qt < ftbs_pkg::NumQtracks &&
        (r.req_type == ftbs_pkg::ReqRead ||
         (r.req_type == ftbs_pkg::ReqWrite && wr_en))) begin
      lo = (r.req_type == ftbs_pkg::ReqWrite && qt > 0) ? qt - 1 : qt;
      hi = (r.req_type == ftbs_pkg::ReqWrite && qt + 1 < ftbs_pkg::NumQtracks) ?
           qt + 1 : qt;
      for (int unsigned t = lo; t <= hi; t++) begin
        if (!disk_bytes.exists(byte_key(t))) begin
          ld = '0;
          ld.req_type = ftbs_pkg::ReqLoad;
          ld.quarter_track = t[7:0];
          ld.byte_index = head_byte;
          ld.byte_value = 8'($urandom);
          send_beat(ld);
        end
      end
    end
    send_beat(r);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_reg(logic idx, logic val);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == ftbs_pkg::CfgDiskLoaded) loaded = val;
    else wr_en = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic ftbs_pkg::req_t make_req(logic [2:0] op, logic [7:0] qt);
    ftbs_pkg::req_t r;
    r.req_type = op;
    r.quarter_track = qt;
    r.write_value = 1'($urandom);
    r.track_length = 16'($urandom);
    r.byte_index = 13'($urandom);
    r.byte_value = 8'($urandom);
    return r;
  endfunction

  task automatic op(logic [2:0] code, logic [7:0] qt);
    issue(make_req(code, qt));
  endtask

  task automatic set_len(logic [7:0] qt, logic [15:0] len);
    ftbs_pkg::req_t r;
    r = make_req(ftbs_pkg::ReqSetLen, qt);
    r.track_length = len;
    issue(r);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    ftbs_pkg::res_t e;
    if (rst_ni && done_o) begin
      results_seen++;
      if (result_q.size() == 0) begin
        $display("%0t: result with none outstanding, actual %p", $time, res_o);
        errors++;
      end else begin
        e = result_q.pop_front();
        if (res_o.read_bit !== e.read_bit || res_o.track_present !== e.track_present ||
            res_o.bit_position !== e.bit_position ||
            res_o.was_modified !== e.was_modified || res_o.status !== e.status) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, res_o);
          errors++;
        end
      end
    end
  end

  task automatic test_unloaded();
    op(ftbs_pkg::ReqRotate, 8'd0);
    op(ftbs_pkg::ReqRead, 8'd3);
    op(ftbs_pkg::ReqWrite, 8'd5);
    set_len(8'd1, 16'd100);
    write_reg(ftbs_pkg::CfgDiskLoaded, 1'b1);
  endtask

  task automatic test_illegal();
    op(ftbs_pkg::ReqRotate, 8'd160);
    op(ftbs_pkg::ReqRead, 8'd255);
    op(ReqRsvdA, 8'd0);
    op(ReqRsvdB, 8'd1);
    op(ReqRsvdC, 8'd2);
  endtask

  task automatic test_track_wrap();
    set_len(8'd0, 16'd10);
    repeat (11) op(ftbs_pkg::ReqRotate, 8'd0);
    op(ftbs_pkg::ReqRead, 8'd0);
  endtask

  task automatic test_write_edges();
    op(ftbs_pkg::ReqWrite, 8'd0);
    op(ftbs_pkg::ReqWrite, 8'd159);
    op(ftbs_pkg::ReqWrite, 8'd80);
    op(ftbs_pkg::ReqRead, 8'd81);
    op(ftbs_pkg::ReqRead, 8'd1);
    op(ftbs_pkg::ReqRead, 8'd158);
    write_reg(ftbs_pkg::CfgWriteEnabled, 1'b0);
    op(ftbs_pkg::ReqWrite, 8'd80);
    write_reg(ftbs_pkg::CfgWriteEnabled, 1'b1);
  endtask

  task automatic test_rescale();
    op(ftbs_pkg::ReqRotate, 8'd7);       // empty track: no rescale
    set_len(8'd2, 16'd20000);
    set_len(8'd3, 16'd20001);
    op(ftbs_pkg::ReqRotate, 8'd2);
    op(ftbs_pkg::ReqRotate, 8'd3);       // tiny change: skipped
    set_len(8'd4, 16'd65535);
    set_len(8'd3, 16'd1);
    op(ftbs_pkg::ReqRotate, 8'd4);       // saturates
    set_len(8'd5, 16'd50000);
    op(ftbs_pkg::ReqRotate, 8'd5);
  endtask

  task automatic test_random(int n);
    logic [7:0] pool [6];
    logic [7:0] qt;
    ftbs_pkg::req_t r;
    int k;
    pool = '{8'd0, 8'd1, 8'd2, 8'd40, 8'd41, 8'd159};
    for (int i = 0; i < n; i++) begin
      qt = ($urandom_range(19) == 0) ? 8'($urandom) : pool[$urandom_range(5)];
      k = $urandom_range(99);
      if (k < 45) r = make_req(ftbs_pkg::ReqRotate, qt);
      else if (k < 65) r = make_req(ftbs_pkg::ReqRead, qt);
      else if (k < 80) r = make_req(ftbs_pkg::ReqWrite, qt);
      else if (k < 88) begin
        r = make_req(ftbs_pkg::ReqSetLen, qt);
        case ($urandom_range(9))
          0: r.track_length = '0;
          1: r.track_length = 16'hFFFF;
          2: ;
          default: r.track_length = 16'($urandom_range(8, 400));
        endcase
      end else if (k < 95) r = make_req(ftbs_pkg::ReqLoad, qt);
      else r = make_req(3'($urandom_range(5, 7)), qt);
      issue(r);
    end
  endtask

  initial begin
    for (int i = 0; i < ftbs_pkg::NumQtracks; i++) len_tbl[i] = '0;
    head_byte = '0;
    head_bit = '0;
    last_qt = '0;
    dirty = 1'b0;
    loaded = 1'b0;
    wr_en = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_unloaded();
    test_illegal();
    test_track_wrap();
    test_write_edges();
    test_rescale();
    drain();                             // hold off until all results are back
    idle_pct = 0;
    test_random(250);
    idle_pct = 35;
    test_random(500);
    write_reg(ftbs_pkg::CfgWriteEnabled, 1'b0);
    test_random(250);
    write_reg(ftbs_pkg::CfgDiskLoaded, 1'b0);
    test_random(80);
    write_reg(ftbs_pkg::CfgDiskLoaded, 1'b1);
    write_reg(ftbs_pkg::CfgWriteEnabled, 1'b1);
    test_random(320);
    drain();
    repeat (60) @(posedge clk_i);
    $display("Covered %0d beats, %0d results, %0d rescales, %0d track bytes touched.",
             items_sent, results_seen, rescales, disk_bytes.num());
    if (errors == 0 && result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ftbs_pkg.sv
hw/rtl/ftbs_divider.sv
hw/rtl/floppy_track_bit_stream_unit.sv
sim/tb.sv
